// File: src/iarr_pkg.sv
// shared types and constants for the angle register reader
package iarr_pkg;

   // request word: one bus tick
   typedef struct packed {
      logic cmd;
      logic sda_in;
   } iarr_req_type;

   // response word: line drive, status and kept angle
   typedef struct packed {
      logic               scl_low;
      logic               sda_low;
      logic               busy_res;
      logic               done_res;
      logic               ok;
      logic [11:0]        raw_angle;
      logic signed [15:0] degrees_x100;
   } iarr_rsp_type;

   // bus side of the response, from the sequencer
   typedef struct packed {
      logic scl_low;
      logic sda_low;
      logic busy_res;
      logic done_res;
      logic ok;
   } iarr_bus_type;

   // sequencer to converter control
   typedef struct packed {
      logic        load_raw;
      logic        mul_step;
      logic        commit;
      logic [11:0] raw;
   } iarr_conv_ctl_type;

   // configuration register indexes
   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_ANGLE_OFFSET   = 1'b1;

   // configuration reset values
   localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'd54;
   localparam logic [15:0] ANGLE_OFFSET_RESET   = 16'd0;

   // register pointer sent after the address byte
   localparam logic [7:0] REG_ANGLE_HI = 8'h0E;

   // conversion constants, hundredths of a degree
   localparam logic [15:0]        DEG_SCALE = 16'd36000;
   localparam logic signed [17:0] DEG_HALF  = 18'sd18000;
   localparam logic signed [17:0] DEG_FULL  = 18'sd36000;

endpackage

// File: src/iarr_seq.sv
// bit-level bus sequencer: start, address, pointer, repeated start, two reads, stop
module iarr_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  iarr_pkg::iarr_req_type      req,
   input  logic [6:0]                  device_address,
   output iarr_pkg::iarr_bus_type      bus,
   output iarr_pkg::iarr_conv_ctl_type conv_ctl
);

   // phase codes
   localparam logic [3:0] PH_IDLE  = 4'd0;
   localparam logic [3:0] PH_ST_A  = 4'd1;
   localparam logic [3:0] PH_ST_B  = 4'd2;
   localparam logic [3:0] PH_W_LO  = 4'd3;
   localparam logic [3:0] PH_W_HI  = 4'd4;
   localparam logic [3:0] PH_WA_LO = 4'd5;
   localparam logic [3:0] PH_WA_HI = 4'd6;
   localparam logic [3:0] PH_RS_LO = 4'd7;
   localparam logic [3:0] PH_R_LO  = 4'd8;
   localparam logic [3:0] PH_R_HI  = 4'd9;
   localparam logic [3:0] PH_RA_LO = 4'd10;
   localparam logic [3:0] PH_RA_HI = 4'd11;
   localparam logic [3:0] PH_SP_A  = 4'd12;
   localparam logic [3:0] PH_SP_B  = 4'd13;
   localparam logic [3:0] PH_SP_C  = 4'd14;

   // transaction stage codes
   localparam logic [2:0] STG_ADDR_W = 3'd0;
   localparam logic [2:0] STG_PTR    = 3'd1;
   localparam logic [2:0] STG_ADDR_R = 3'd2;
   localparam logic [2:0] STG_RD_HI  = 3'd3;
   localparam logic [2:0] STG_RD_LO  = 3'd4;

   logic [3:0] phase_ff, phase_in;
   logic [2:0] stage_ff, stage_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] shift_reg_ff, shift_reg_in;
   logic [7:0] high_byte_ff, high_byte_in;
   logic       success_ff, success_in;

   // next state and line drive for one tick
   always_comb begin
      logic [3:0] ph;
      logic [2:0] stg;
      logic       succ;
      logic [3:0] bc_inc;
      logic       start;

      start  = (phase_ff == PH_IDLE) && req.cmd;
      ph     = start ? PH_ST_A : phase_ff;
      stg    = start ? STG_ADDR_W : stage_ff;
      succ   = start ? 1'b0 : success_ff;
      bc_inc = bit_count_ff + 4'd1;

      phase_in     = ph;
      stage_in     = stg;
      success_in   = succ;
      bit_count_in = bit_count_ff;
      shift_reg_in = shift_reg_ff;
      high_byte_in = high_byte_ff;

      bus          = '0;
      bus.busy_res = (ph != PH_IDLE);
      conv_ctl     = '0;
      conv_ctl.raw = {high_byte_ff[3:0], shift_reg_ff};

      case (ph)
         PH_ST_A: begin
            phase_in = PH_ST_B;
         end
         PH_ST_B: begin
            bus.sda_low  = 1'b1;
            shift_reg_in = {device_address, stg != STG_ADDR_W};
            bit_count_in = 4'd0;
            phase_in     = PH_W_LO;
         end
         PH_W_LO: begin
            bus.scl_low = 1'b1;
            bus.sda_low = !shift_reg_ff[7];
            phase_in    = PH_W_HI;
         end
         PH_W_HI: begin
            bus.sda_low  = !shift_reg_ff[7];
            shift_reg_in = {shift_reg_ff[6:0], 1'b0};
            bit_count_in = bc_inc;
            phase_in     = bc_inc[3] ? PH_WA_LO : PH_W_LO;
         end
         PH_WA_LO: begin
            bus.scl_low = 1'b1;
            phase_in    = PH_WA_HI;
         end
         PH_WA_HI: begin
            // slave ack sampled on the high half
            if (req.sda_in) begin
               success_in = 1'b0;
               phase_in   = PH_SP_A;
            end else if (stg == STG_ADDR_W) begin
               stage_in     = STG_PTR;
               shift_reg_in = iarr_pkg::REG_ANGLE_HI;
               bit_count_in = 4'd0;
               phase_in     = PH_W_LO;
            end else if (stg == STG_PTR) begin
               phase_in = PH_RS_LO;
            end else begin
               stage_in     = STG_RD_HI;
               shift_reg_in = 8'd0;
               bit_count_in = 4'd0;
               phase_in     = PH_R_LO;
            end
         end
         PH_RS_LO: begin
            bus.scl_low = 1'b1;
            stage_in    = STG_ADDR_R;
            phase_in    = PH_ST_A;
         end
         PH_R_LO: begin
            bus.scl_low = 1'b1;
            phase_in    = PH_R_HI;
         end
         PH_R_HI: begin
            shift_reg_in = {shift_reg_ff[6:0], req.sda_in};
            bit_count_in = bc_inc;
            phase_in     = bc_inc[3] ? PH_RA_LO : PH_R_LO;
         end
         PH_RA_LO: begin
            bus.scl_low = 1'b1;
            bus.sda_low = (stg == STG_RD_HI);
            phase_in    = PH_RA_HI;
         end
         PH_RA_HI: begin
            // ack after the first byte, nack after the second
            bus.sda_low = (stg == STG_RD_HI);
            if (stg == STG_RD_HI) begin
               high_byte_in = shift_reg_ff;
               stage_in     = STG_RD_LO;
               shift_reg_in = 8'd0;
               bit_count_in = 4'd0;
               phase_in     = PH_R_LO;
            end else begin
               success_in        = 1'b1;
               conv_ctl.load_raw = accept;
               phase_in          = PH_SP_A;
            end
         end
         PH_SP_A: begin
            bus.scl_low       = 1'b1;
            bus.sda_low       = 1'b1;
            conv_ctl.mul_step = accept;
            phase_in          = PH_SP_B;
         end
         PH_SP_B: begin
            bus.sda_low = 1'b1;
            phase_in    = PH_SP_C;
         end
         PH_SP_C: begin
            bus.done_res    = 1'b1;
            bus.ok          = succ;
            conv_ctl.commit = accept && succ;
            phase_in        = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // sequencer state, advanced once per accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         stage_ff     <= STG_ADDR_W;
         bit_count_ff <= 4'd0;
         shift_reg_ff <= 8'd0;
         high_byte_ff <= 8'd0;
         success_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         stage_ff     <= stage_in;
         bit_count_ff <= bit_count_in;
         shift_reg_ff <= shift_reg_in;
         high_byte_ff <= high_byte_in;
         success_ff   <= success_in;
      end
   end

endmodule

// File: src/iarr_conv.sv
// raw angle to hundredths of a degree, spread over the stop ticks
module iarr_conv (
   input  logic                        clock,
   input  logic                        reset,
   input  iarr_pkg::iarr_conv_ctl_type conv_ctl,
   input  logic signed [15:0]          angle_offset,
   output logic [11:0]                 raw_angle,
   output logic signed [15:0]          degrees_x100
);

   logic [11:0]        raw_pend_ff;
   logic [15:0]        prod_ff;
   logic [11:0]        kept_raw_ff;
   logic signed [15:0] kept_deg_ff;
   logic [27:0]        prod_full;
   logic signed [17:0] sum;
   logic signed [17:0] wrapped;

   // scale by 36000/4096, truncated
   assign prod_full = {16'd0, raw_pend_ff} * {12'd0, iarr_pkg::DEG_SCALE};

   // offset as it stands on the final stop tick
   assign sum = $signed({2'b00, prod_ff}) + 18'(angle_offset);

   // fold sums at or above the half turn down by one full turn
   assign wrapped = (sum >= iarr_pkg::DEG_HALF) ? (sum - iarr_pkg::DEG_FULL) : sum;

   // raw capture on the last ack tick, product on the first stop tick
   always_ff @(posedge clock) begin
      if (conv_ctl.load_raw) begin
         raw_pend_ff <= conv_ctl.raw;
      end
      if (conv_ctl.mul_step) begin
         prod_ff <= prod_full[27:12];
      end
   end

   // kept results
   always_ff @(posedge clock) begin
      if (reset) begin
         kept_raw_ff <= 12'd0;
         kept_deg_ff <= 16'sd0;
      end else if (conv_ctl.commit) begin
         kept_raw_ff <= raw_pend_ff;
         kept_deg_ff <= wrapped[15:0];
      end
   end

   // the committing word already shows the new values
   assign raw_angle    = conv_ctl.commit ? raw_pend_ff : kept_raw_ff;
   assign degrees_x100 = conv_ctl.commit ? wrapped[15:0] : kept_deg_ff;

endmodule

// File: src/iarr_rsp_reg.sv
// two-entry response register with skid slot
module iarr_rsp_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  iarr_pkg::iarr_rsp_type push_data,
   output logic                   can_push,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output iarr_pkg::iarr_rsp_type rsp_data
);

   logic                   main_valid_ff;
   logic                   skid_valid_ff;
   iarr_pkg::iarr_rsp_type main_ff;
   iarr_pkg::iarr_rsp_type skid_ff;
   logic                   pop;

   assign pop       = main_valid_ff && rsp_ready;
   assign can_push  = !skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   // words
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_ff <= push_data;
         end else begin
            main_ff <= push_data;
         end
      end
   end

endmodule

// File: src/i2c_angle_register_reader.sv
// top level of the bus angle register reader
//
//   channel   ports                         word
//   request   req_valid/req_ready/req_data  cmd, sda_in (one bus tick)
//   response  rsp_valid/rsp_ready/rsp_data  line drive, status, kept angle
//   config    csr_we/csr_index/csr_wdata    device address, angle offset
//
// One request word per cycle while req_ready is high; each accepted word yields
// one response word, registered in the main slot or, when that is held, the skid slot.
// A full read takes 98 ticks, counting the tick that carries the command.
// Request ready drops only while both response slots are full.
// Reset is synchronous: sequencer idle, kept angle zero, address 54.
module i2c_angle_register_reader (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  iarr_pkg::iarr_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output iarr_pkg::iarr_rsp_type rsp_data,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [15:0]            csr_wdata
);

   logic [6:0]                  device_address_ff;
   logic signed [15:0]          angle_offset_ff;
   logic                        accept;
   iarr_pkg::iarr_bus_type      bus;
   iarr_pkg::iarr_conv_ctl_type conv_ctl;
   iarr_pkg::iarr_rsp_type      rsp_word;
   logic [11:0]                 raw_angle;
   logic signed [15:0]          degrees_x100;

   assign accept = req_valid && req_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= iarr_pkg::DEVICE_ADDRESS_RESET;
         angle_offset_ff   <= iarr_pkg::ANGLE_OFFSET_RESET;
      end else if (csr_we) begin
         case (csr_index)
            iarr_pkg::CSR_DEVICE_ADDRESS: device_address_ff <= csr_wdata[6:0];
            iarr_pkg::CSR_ANGLE_OFFSET:   angle_offset_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // bus sequencer
   iarr_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req            (req_data),
      .device_address (device_address_ff),
      .bus            (bus),
      .conv_ctl       (conv_ctl)
   );

   // angle conversion
   iarr_conv u_conv (
      .clock        (clock),
      .reset        (reset),
      .conv_ctl     (conv_ctl),
      .angle_offset (angle_offset_ff),
      .raw_angle    (raw_angle),
      .degrees_x100 (degrees_x100)
   );

   // assemble the response word
   always_comb begin
      rsp_word.scl_low      = bus.scl_low;
      rsp_word.sda_low      = bus.sda_low;
      rsp_word.busy_res     = bus.busy_res;
      rsp_word.done_res     = bus.done_res;
      rsp_word.ok           = bus.ok;
      rsp_word.raw_angle    = raw_angle;
      rsp_word.degrees_x100 = degrees_x100;
   end

   // response register
   iarr_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (rsp_word),
      .can_push  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: verif/i2c_angle_register_reader_tb.sv
// self-checking testbench for the bus angle register reader
module i2c_angle_register_reader_tb;

   // sequencer phases of the bus master, one per tick
   typedef enum logic [3:0] {
      BUS_IDLE, BUS_START_A, BUS_START_B, BUS_WR_LO, BUS_WR_HI, BUS_WACK_LO,
      BUS_WACK_HI, BUS_RESTART, BUS_RD_LO, BUS_RD_HI, BUS_MACK_LO, BUS_MACK_HI,
      BUS_STOP_A, BUS_STOP_B, BUS_STOP_C
   } bus_phase_type;

   // which byte of the transfer is on the bus
   typedef enum logic [2:0] {
      STG_ADDR_WR, STG_REG_PTR, STG_ADDR_RD, STG_HIGH_BYTE, STG_LOW_BYTE
   } bus_stage_type;

   // ways to fill the ticks that the sequencer ignores
   typedef enum int {FILL_QUIET, FILL_RANDOM, FILL_CMD_HELD} fill_type;

   localparam int NO_NACK = 0;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   iarr_pkg::iarr_req_type req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   iarr_pkg::iarr_rsp_type rsp_data;
   logic                   csr_we;
   logic                   csr_index;
   logic [15:0]            csr_wdata;

   // bus master model state
   bus_phase_type bus_phase;
   bus_stage_type bus_stage;
   logic [3:0]    bus_bits;
   logic [7:0]    bus_shift;
   logic [7:0]    bus_high;
   logic          bus_success;
   logic          drive_scl;
   logic          drive_sda;
   logic [11:0]   kept_raw;
   logic [15:0]   kept_deg;
   logic [6:0]    cfg_addr;
   logic [15:0]   cfg_offset;

   iarr_pkg::iarr_rsp_type expected_rsp[$];
   int mismatches;
   int tick_count;
   int reads_ok;
   int reads_aborted;
   int csr_writes;
   int req_pace_max;
   int rsp_pace_max;
   int hold_left;

   i2c_angle_register_reader u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop if the run hangs
   initial begin
      #5_000_000;
      $display("** i2c_angle_register_reader: FAILED **");
      $finish;
   end

   // model state after reset
   task automatic reset_model();
      bus_phase   = BUS_IDLE;
      bus_stage   = STG_ADDR_WR;
      bus_bits    = '0;
      bus_shift   = '0;
      bus_high    = '0;
      bus_success = 1'b0;
      drive_scl   = 1'b0;
      drive_sda   = 1'b0;
      kept_raw    = '0;
      kept_deg    = '0;
      cfg_addr    = iarr_pkg::DEVICE_ADDRESS_RESET;
      cfg_offset  = iarr_pkg::ANGLE_OFFSET_RESET;
   endtask

   // raw angle to hundredths of a degree, offset added, 180 and above folded down by 360
   task automatic convert_angle();
      logic [11:0] raw;
      int          deg;
      raw = {bus_high[3:0], bus_shift};
      deg = ((int'(raw) * 36000) >>> 12) + int'($signed(cfg_offset));
      if (deg >= 18000) begin
         deg = deg - 36000;
      end
      kept_raw = raw;
      kept_deg = deg[15:0];
   endtask

   // advance the bus master model by one tick and give its response word
   task automatic predict_tick(input iarr_pkg::iarr_req_type w,
                               output iarr_pkg::iarr_rsp_type r);
      logic busy_now;
      logic done_now;
      logic ok_now;
      done_now = 1'b0;
      ok_now   = 1'b0;
      if (bus_phase == BUS_IDLE && w.cmd) begin
         bus_phase   = BUS_START_A;
         bus_stage   = STG_ADDR_WR;
         bus_success = 1'b0;
      end
      busy_now = (bus_phase != BUS_IDLE);
      case (bus_phase)
         BUS_START_A: begin
            drive_scl = 1'b0; drive_sda = 1'b0;
            bus_phase = BUS_START_B;
         end
         BUS_START_B: begin
            drive_scl = 1'b0; drive_sda = 1'b1;
            bus_shift = {cfg_addr, (bus_stage != STG_ADDR_WR)};
            bus_bits  = '0;
            bus_phase = BUS_WR_LO;
         end
         BUS_WR_LO: begin
            drive_scl = 1'b1; drive_sda = ~bus_shift[7];
            bus_phase = BUS_WR_HI;
         end
         BUS_WR_HI: begin
            drive_scl = 1'b0; drive_sda = ~bus_shift[7];
            bus_shift = bus_shift << 1;
            bus_bits  = bus_bits + 4'd1;
            bus_phase = (bus_bits >= 8) ? BUS_WACK_LO : BUS_WR_LO;
         end
         BUS_WACK_LO: begin
            drive_scl = 1'b1; drive_sda = 1'b0;
            bus_phase = BUS_WACK_HI;
         end
         BUS_WACK_HI: begin
            drive_scl = 1'b0; drive_sda = 1'b0;
            if (w.sda_in) begin
               bus_success = 1'b0;
               bus_phase   = BUS_STOP_A;
            end else if (bus_stage == STG_ADDR_WR) begin
               bus_stage = STG_REG_PTR;
               bus_shift = iarr_pkg::REG_ANGLE_HI;
               bus_bits  = '0;
               bus_phase = BUS_WR_LO;
            end else if (bus_stage == STG_REG_PTR) begin
               bus_phase = BUS_RESTART;
            end else begin
               bus_stage = STG_HIGH_BYTE;
               bus_shift = '0;
               bus_bits  = '0;
               bus_phase = BUS_RD_LO;
            end
         end
         BUS_RESTART: begin
            drive_scl = 1'b1; drive_sda = 1'b0;
            bus_stage = STG_ADDR_RD;
            bus_phase = BUS_START_A;
         end
         BUS_RD_LO: begin
            drive_scl = 1'b1; drive_sda = 1'b0;
            bus_phase = BUS_RD_HI;
         end
         BUS_RD_HI: begin
            drive_scl = 1'b0; drive_sda = 1'b0;
            bus_shift = {bus_shift[6:0], w.sda_in};
            bus_bits  = bus_bits + 4'd1;
            bus_phase = (bus_bits >= 8) ? BUS_MACK_LO : BUS_RD_LO;
         end
         BUS_MACK_LO: begin
            drive_scl = 1'b1; drive_sda = (bus_stage == STG_HIGH_BYTE);
            bus_phase = BUS_MACK_HI;
         end
         BUS_MACK_HI: begin
            drive_scl = 1'b0; drive_sda = (bus_stage == STG_HIGH_BYTE);
            if (bus_stage == STG_HIGH_BYTE) begin
               bus_high  = bus_shift;
               bus_stage = STG_LOW_BYTE;
               bus_shift = '0;
               bus_bits  = '0;
               bus_phase = BUS_RD_LO;
            end else begin
               bus_success = 1'b1;
               bus_phase   = BUS_STOP_A;
            end
         end
         BUS_STOP_A: begin
            drive_scl = 1'b1; drive_sda = 1'b1;
            bus_phase = BUS_STOP_B;
         end
         BUS_STOP_B: begin
            drive_scl = 1'b0; drive_sda = 1'b1;
            bus_phase = BUS_STOP_C;
         end
         BUS_STOP_C: begin
            drive_scl = 1'b0; drive_sda = 1'b0;
            if (bus_success) begin
               convert_angle();
               reads_ok++;
            end else begin
               reads_aborted++;
            end
            done_now  = 1'b1;
            ok_now    = bus_success;
            bus_phase = BUS_IDLE;
         end
         default: begin
            drive_scl = 1'b0; drive_sda = 1'b0;
            bus_phase = BUS_IDLE;
         end
      endcase
      r.scl_low      = drive_scl;
      r.sda_low      = drive_sda;
      r.busy_res     = busy_now;
      r.done_res     = done_now;
      r.ok           = ok_now;
      r.raw_angle    = kept_raw;
      r.degrees_x100 = kept_deg;
   endtask

   // one line per mismatch, printing capped
   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= 30) begin
         $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      end
   endtask

   // field by field compare of one response word
   task automatic check_rsp(input iarr_pkg::iarr_rsp_type got,
                            input iarr_pkg::iarr_rsp_type want);
      if (got.scl_low !== want.scl_low)
         report_mismatch("scl_low", got.scl_low, want.scl_low);
      if (got.sda_low !== want.sda_low)
         report_mismatch("sda_low", got.sda_low, want.sda_low);
      if (got.busy_res !== want.busy_res)
         report_mismatch("busy_res", got.busy_res, want.busy_res);
      if (got.done_res !== want.done_res)
         report_mismatch("done_res", got.done_res, want.done_res);
      if (got.ok !== want.ok)
         report_mismatch("ok", got.ok, want.ok);
      if (got.raw_angle !== want.raw_angle)
         report_mismatch("raw_angle", got.raw_angle, want.raw_angle);
      if (got.degrees_x100 !== want.degrees_x100)
         report_mismatch("degrees_x100", got.degrees_x100, want.degrees_x100);
   endtask

   // response checker, draws the next receiver stall on each word
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected response word", 1, 0);
         end else begin
            check_rsp(rsp_data, expected_rsp.pop_front());
         end
         hold_left = $urandom_range(0, rsp_pace_max);
      end
   end

   // receiver ready, lowered for the drawn stall
   initial begin
      rsp_ready = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // send one tick word, predict its response on acceptance
   task automatic send_tick(input iarr_pkg::iarr_req_type w);
      int                     gap;
      iarr_pkg::iarr_rsp_type want;
      gap = $urandom_range(0, req_pace_max);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  = w;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_tick(w, want);
      expected_rsp.push_back(want);
      tick_count++;
      @(negedge clock);
   endtask

   // ticks with no command, sda noise only
   task automatic run_idle_ticks(input int n);
      iarr_pkg::iarr_req_type w;
      repeat (n) begin
         w.cmd    = 1'b0;
         w.sda_in = 1'($urandom_range(0, 1));
         send_tick(w);
      end
   endtask

   // one full read: slave acks except at nack_at, returns angle_bits msb first
   task automatic run_read(input logic [15:0] angle_bits, input int nack_at,
                           input fill_type fill);
      iarr_pkg::iarr_req_type w;
      int                     acks;
      int                     bit_idx;
      acks    = 0;
      bit_idx = 15;
      w.cmd    = 1'b1;
      w.sda_in = (fill == FILL_RANDOM) ? 1'($urandom_range(0, 1)) : 1'b0;
      send_tick(w);
      while (bus_phase != BUS_IDLE) begin
         case (fill)
            FILL_QUIET:    begin w.cmd = 1'b0; w.sda_in = 1'b1; end
            FILL_RANDOM:   begin w.cmd = 1'($urandom_range(0, 1));
                                 w.sda_in = 1'($urandom_range(0, 1)); end
            default:       begin w.cmd = 1'b1; w.sda_in = 1'b0; end
         endcase
         if (bus_phase == BUS_WACK_HI) begin
            acks++;
            w.sda_in = (acks == nack_at);
         end else if (bus_phase == BUS_RD_HI) begin
            w.sda_in = angle_bits[bit_idx];
            bit_idx--;
         end
         send_tick(w);
      end
   endtask

   // register write once every response is back
   task automatic write_csr(input logic index, input logic [15:0] value);
      req_valid = 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(posedge clock);
      if (index == iarr_pkg::CSR_DEVICE_ADDRESS) begin
         cfg_addr = value[6:0];
      end else begin
         cfg_offset = value;
      end
      @(negedge clock);
      csr_we = 1'b0;
      csr_writes++;
   endtask

   task automatic set_config(input logic [6:0] addr, input logic [15:0] offset);
      write_csr(iarr_pkg::CSR_DEVICE_ADDRESS, {9'd0, addr});
      write_csr(iarr_pkg::CSR_ANGLE_OFFSET, offset);
   endtask

   // full reads at the raw angle extremes and around the fold point
   task automatic test_full_reads();
      run_read(16'h0FFF, NO_NACK, FILL_QUIET);
      run_read(16'h0000, NO_NACK, FILL_QUIET);
      run_read(16'h0800, NO_NACK, FILL_QUIET);
      run_read(16'h07FF, NO_NACK, FILL_QUIET);
      run_read(16'hF000, NO_NACK, FILL_QUIET);
   endtask

   // nack on address write, register pointer and address read
   task automatic test_nack_abort();
      run_read(16'h0ABC, 1, FILL_QUIET);
      run_read(16'h0ABC, 2, FILL_QUIET);
      run_read(16'h0ABC, 3, FILL_QUIET);
      run_read(16'h0123, NO_NACK, FILL_QUIET);
   endtask

   // commands while busy and sda on non-sampling ticks are ignored
   task automatic test_ignored_inputs();
      run_idle_ticks(6);
      run_read(16'h5A5A, NO_NACK, FILL_CMD_HELD);
      run_read(16'hA5A5, NO_NACK, FILL_RANDOM);
      run_idle_ticks(4);
   endtask

   // address and offset at their extremes
   task automatic test_config_extremes();
      set_config(7'd127, 16'h7FFF);
      run_read(16'h0FFF, NO_NACK, FILL_QUIET);
      run_read(16'h0000, NO_NACK, FILL_QUIET);
      set_config(7'd0, 16'h8000);
      run_read(16'h0000, NO_NACK, FILL_QUIET);
      run_read(16'h0FFF, 2, FILL_QUIET);
      run_read(16'h0FFF, NO_NACK, FILL_RANDOM);
   endtask

   // mostly well-formed reads with random content, some aborts and noise
   task automatic test_random_traffic(input int tick_target);
      int          stop_at;
      int          reads;
      int          nack_at;
      fill_type    fill;
      logic [15:0] offset;
      stop_at = tick_count + tick_target;
      reads   = 0;
      while (tick_count < stop_at) begin
         if (reads % 2 == 1) begin
            case ($urandom_range(0, 3))
               0:       offset = 16'h7FFF;
               1:       offset = 16'h8000;
               default: offset = 16'($urandom_range(0, 16'hFFFF));
            endcase
            set_config(7'($urandom_range(0, 127)), offset);
         end
         req_pace_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
         rsp_pace_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
         nack_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : NO_NACK;
         case ($urandom_range(0, 5))
            0:       fill = FILL_QUIET;
            1:       fill = FILL_CMD_HELD;
            default: fill = FILL_RANDOM;
         endcase
         if ($urandom_range(0, 4) == 0) begin
            run_idle_ticks($urandom_range(1, 5));
         end
         run_read(16'($urandom_range(0, 16'hFFFF)), nack_at, fill);
         reads++;
      end
   endtask

   // main sequence
   initial begin
      int guard;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_we       = 1'b0;
      csr_index    = iarr_pkg::CSR_DEVICE_ADDRESS;
      csr_wdata    = '0;
      mismatches   = 0;
      tick_count   = 0;
      reads_ok     = 0;
      reads_aborted = 0;
      csr_writes   = 0;
      req_pace_max = 14;
      rsp_pace_max = 14;
      reset_model();
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_full_reads();
      test_nack_abort();
      test_ignored_inputs();
      test_config_extremes();
      test_random_traffic(450);

      // drain
      req_valid = 1'b0;
      guard = 0;
      while (expected_rsp.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         report_mismatch("response words never seen", 0, expected_rsp.size());
      end

      $display("covered %0d ticks: %0d reads completed, %0d aborted on nack",
               tick_count, reads_ok, reads_aborted);
      $display("%0d register writes, %0d mismatches", csr_writes, mismatches);
      if (mismatches == 0) begin
         $display("** i2c_angle_register_reader: PASSED **");
      end else begin
         $display("** i2c_angle_register_reader: FAILED **");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/iarr_pkg.sv
src/iarr_seq.sv
src/iarr_conv.sv
src/iarr_rsp_reg.sv
src/i2c_angle_register_reader.sv
verif/i2c_angle_register_reader_tb.sv
